/* hdl/igrx_pkg.sv */
// Shared types and constants for the idle-gap receive packet FIFO.
// Item structs, command codes and the controller/datapath link.
// No dependencies.
package igrx_pkg;

  // Command codes carried in the input item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  // Configuration register indexes
  localparam logic CFG_IDLE_GAP    = 1'b0;
  localparam logic CFG_PACKET_MODE = 1'b1;

  // Reset values and limits
  localparam logic [15:0] IDLE_GAP_RESET = 16'd10;
  localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_in;
    logic [6:0] read_limit;
    logic       packet_only;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       last;
    logic       accepted;
    logic       packet_ready;
    logic [6:0] fill_level;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic tick;
    logic write;
    logic flush;
    logic rd_empty;
    logic rd_load;
    logic rd_step;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic remain_one;
  } dp_stat_t;

endpackage

/* hdl/igrx_ctrl.sv */
// Controller for the idle-gap receive packet FIFO.
// Decodes accepted items and sequences multi-byte reads; depends on igrx_pkg.
module igrx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        command,
  input  igrx_pkg::dp_stat_t stat,
  output igrx_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import igrx_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy   = (state_r == ST_READ);
  assign accept = start && (state_r == ST_IDLE);

  // Decode the command and pick the next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_TICK:  cmd.tick  = 1'b1;
            CMD_WRITE: cmd.write = 1'b1;
            CMD_FLUSH: cmd.flush = 1'b1;
            CMD_READ: begin
              if (stat.count_zero) begin
                cmd.rd_empty = 1'b1;
              end else begin
                cmd.rd_load = 1'b1;
                state_nxt   = ST_READ;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_step = 1'b1;
        if (stat.remain_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/igrx_dp.sv */
// Datapath for the idle-gap receive packet FIFO: ring memory, indices,
// fill and idle counters, configuration and result register; uses igrx_pkg.
module igrx_dp #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  igrx_pkg::in_item_t  in_item,
  input  igrx_pkg::dp_cmd_t   cmd,
  output igrx_pkg::dp_stat_t  stat,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_strobe,
  output igrx_pkg::out_item_t out_item
);
  import igrx_pkg::*;

  localparam int IDX_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [CNT_W-1:0] remain_r;
  logic [15:0]      gap_r;
  logic             pmode_r;

  logic             strobe_r, valid_r, last_r, acc_r, ready_r;
  logic [CNT_W-1:0] lvl_r;
  logic [7:0]       rd_data_r;
  logic             last_nxt, acc_nxt, ready_nxt;

  logic             ready_now, full, pre_flush, mem_we;
  logic [IDX_W-1:0] wr_pos;
  logic [6:0]       fill7, count7;
  logic [CNT_W-1:0] count;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign ready_now = (fill_r != '0) && (idle_r > gap_r);
  assign full      = (fill_r == CNT_W'(FIFO_DEPTH));
  assign pre_flush = pmode_r && ready_now;
  assign wr_pos    = pre_flush ? '0 : wr_idx_r;
  assign mem_we    = cmd.write && !full;

  // Bytes a read returns: the smaller of limit and fill, none if no packet
  assign fill7  = 7'(fill_r);
  assign count7 = (in_item.read_limit < fill7) ? in_item.read_limit : fill7;
  assign count  = (in_item.packet_only && !ready_now) ? '0 : CNT_W'(count7);

  assign stat.count_zero = (count == '0);
  assign stat.remain_one = (remain_r == CNT_W'(1));

  // Next state of indices and counters
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    idle_nxt   = idle_r;
    last_nxt   = 1'b1;
    acc_nxt    = 1'b0;
    if (cmd.tick && idle_r != IDLE_MAX) begin
      idle_nxt = idle_r + 16'd1;
    end
    if (mem_we) begin
      wr_idx_nxt = next_idx(wr_pos);
      rd_idx_nxt = pre_flush ? '0 : rd_idx_r;
      fill_nxt   = (pre_flush ? '0 : fill_r) + 1'b1;
      idle_nxt   = '0;
      acc_nxt    = 1'b1;
    end
    if (cmd.flush) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      fill_nxt   = '0;
    end
    if (cmd.rd_step) begin
      rd_idx_nxt = next_idx(rd_idx_r);
      fill_nxt   = fill_r - 1'b1;
      last_nxt   = stat.remain_one;
    end
    ready_nxt = (fill_nxt != '0) && (idle_nxt > gap_r);
  end

  // Hold control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      fill_r   <= '0;
      idle_r   <= '0;
      remain_r <= '0;
      gap_r    <= IDLE_GAP_RESET;
      pmode_r  <= 1'b0;
      strobe_r <= 1'b0;
      valid_r  <= 1'b0;
      last_r   <= 1'b0;
      acc_r    <= 1'b0;
      ready_r  <= 1'b0;
      lvl_r    <= '0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      fill_r   <= fill_nxt;
      idle_r   <= idle_nxt;
      if (cmd.rd_load) begin
        remain_r <= count;
      end else if (cmd.rd_step) begin
        remain_r <= remain_r - 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_IDLE_GAP) begin
          gap_r <= cfg_data;
        end else begin
          pmode_r <= cfg_data[0];
        end
      end
      // Register one result per non-loading command
      strobe_r <= cmd.tick || cmd.write || cmd.flush || cmd.rd_empty || cmd.rd_step;
      valid_r  <= cmd.rd_step;
      last_r   <= last_nxt;
      acc_r    <= acc_nxt;
      ready_r  <= ready_nxt;
      lvl_r    <= fill_nxt;
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_pos] <= in_item.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_step) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  assign out_strobe            = strobe_r;
  assign out_item.data_out     = valid_r ? rd_data_r : 8'd0;
  assign out_item.data_valid   = valid_r;
  assign out_item.last         = last_r;
  assign out_item.accepted     = acc_r;
  assign out_item.packet_ready = ready_r;
  assign out_item.fill_level   = 7'(lvl_r);

endmodule

/* hdl/idle_gap_rx_packet_fifo.sv */
// Top level of the idle-gap receive packet FIFO.
// Joins igrx_ctrl and igrx_dp; uses igrx_pkg.
//
// Tick, write, flush and a read that returns no bytes never raise busy: the
// single result appears on the cycle after start is taken, and a new item may
// be started on that same cycle. A read of n bytes holds busy high while its
// bytes are stepped out, since the ring memory has one registered read port
// and gives one byte per cycle; its results follow back to back, after the
// controller's load and the registered read, the final one marked last. Every
// result is presented for one cycle with out_strobe high and must be taken
// then. Configuration writes are always ready and take effect at once.
module idle_gap_rx_packet_fifo #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  igrx_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output igrx_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import igrx_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  igrx_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_item.command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  igrx_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Single-result commands transfer their result on the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.command != CMD_READ) |=> out_strobe)
    else $error("single-result command gave no result");

  // A read sequence ends with its last byte
  a_read_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_item.last && out_item.data_valid))
    else $error("read sequence ended without last byte");

  // Fill level never exceeds the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.fill_level <= 7'(FIFO_DEPTH)))
    else $error("fill level beyond depth");

  // A data byte is never flagged as a stored write
  a_valid_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.data_valid) |-> !out_item.accepted)
    else $error("read byte flagged accepted");

endmodule

/* dv/tb_idle_gap_rx_packet_fifo.sv */
// Testbench for idle_gap_rx_packet_fifo: tick, write, read and flush transfers
// with random gaps, every result predicted and checked field by field.
// Depends on igrx_pkg and the block's RTL.
module tb_idle_gap_rx_packet_fifo;
  import igrx_pkg::*;

  localparam int DEPTH = 64;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // Predicted FIFO contents, pointers, idle counter and register settings
  logic [7:0]  ring_copy [DEPTH];
  int unsigned rd_ptr;
  int unsigned wr_ptr;
  int unsigned held_bytes;
  int unsigned idle_ticks;
  logic [15:0] gap_setting;
  logic        pkt_mode;

  out_item_t   expected_results [$];
  int unsigned mismatches;
  int unsigned items_sent;
  bit          no_idle;

  idle_gap_rx_packet_fifo #(.FIFO_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Stop a hung run
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  function automatic logic packet_ready_now();
    return (held_bytes > 0) && (idle_ticks > gap_setting);
  endfunction

  // Queue one result, with status taken from the predicted state as it stands
  function automatic void push_result(input logic [7:0] data, input logic valid,
                                      input logic last, input logic acc);
    out_item_t r;
    r.data_out     = data;
    r.data_valid   = valid;
    r.last         = last;
    r.accepted     = acc;
    r.packet_ready = packet_ready_now();
    r.fill_level   = 7'(held_bytes);
    expected_results.push_back(r);
  endfunction

  function automatic void empty_ring();
    held_bytes = 0;
    rd_ptr     = 0;
    wr_ptr     = 0;
  endfunction

  // Advance the predicted FIFO by one item and queue the results it causes
  function automatic void predict_fifo_results(input in_item_t it);
    int unsigned count;
    int unsigned k;
    case (it.command)
      CMD_TICK: begin
        if (idle_ticks < IDLE_MAX) idle_ticks++;
        push_result(8'h00, 1'b0, 1'b1, 1'b0);
      end
      CMD_WRITE: begin
        if (held_bytes >= DEPTH) begin
          push_result(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
          // a ready packet is thrown away before the new byte in packet mode
          if (pkt_mode && packet_ready_now()) empty_ring();
          ring_copy[wr_ptr] = it.data_in;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          held_bytes++;
          idle_ticks = 0;
          push_result(8'h00, 1'b0, 1'b1, 1'b1);
        end
      end
      CMD_FLUSH: begin
        empty_ring();
        push_result(8'h00, 1'b0, 1'b1, 1'b0);
      end
      CMD_READ: begin
        count = (it.read_limit < held_bytes) ? it.read_limit : held_bytes;
        if (it.packet_only && !packet_ready_now()) count = 0;
        if (count == 0) push_result(8'h00, 1'b0, 1'b1, 1'b0);
        for (k = 0; k < count; k++) begin
          held_bytes--;
          push_result(ring_copy[rd_ptr], 1'b1, k + 1 == count, 1'b0);
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
      end
      default: ;
    endcase
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_item));
      end else begin
        want = expected_results.pop_front();
        check_field("data_out", out_item.data_out, want.data_out);
        check_field("data_valid", out_item.data_valid, want.data_valid);
        check_field("last", out_item.last, want.last);
        check_field("accepted", out_item.accepted, want.accepted);
        check_field("packet_ready", out_item.packet_ready, want.packet_ready);
        check_field("fill_level", out_item.fill_level, want.fill_level);
      end
    end
  end

  // Mostly short gaps, a few long ones, none while no_idle is set
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one item, wait for its transfer, then hold start or idle a while.
  // Called and returns at a falling edge.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_fifo_results(it);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data,
                          input logic [6:0] limit, input logic only);
    in_item_t it;
    it.command     = cmd;
    it.data_in     = data;
    it.read_limit  = limit;
    it.packet_only = only;
    send_item(it);
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic wait_until_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(input logic idx, input logic [15:0] value);
    wait_until_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_IDLE_GAP) gap_setting = value;
    else pkt_mode = value[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Every command at reset settings: empty reads, byte extremes, gap boundary
  task automatic test_each_command();
    send_cmd(CMD_READ, 8'h3C, 7'd5, 1'b0);
    send_cmd(CMD_TICK, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_WRITE, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_WRITE, 8'hFF, 7'h7F, 1'b1);
    send_cmd(CMD_WRITE, 8'hA5, 7'h2A, 1'b0);
    send_cmd(CMD_WRITE, 8'h5A, 7'h55, 1'b1);
    send_cmd(CMD_READ, 8'h00, 7'd64, 1'b1);
    repeat (11) send_cmd(CMD_TICK, 8'hFF, 7'h7F, 1'b1);
    send_cmd(CMD_READ, 8'h00, 7'd2, 1'b1);
    send_cmd(CMD_READ, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_READ, 8'h00, 7'h7F, 1'b0);
    send_cmd(CMD_WRITE, 8'h81, 7'd0, 1'b0);
    send_cmd(CMD_FLUSH, 8'hFF, 7'h7F, 1'b1);
    send_cmd(CMD_READ, 8'h00, 7'd64, 1'b0);
  endtask

  // Packet mode with a zero gap: a byte after one tick replaces the packet
  task automatic test_packet_mode();
    write_config(CFG_IDLE_GAP, 16'd0);
    write_config(CFG_PACKET_MODE, 16'd1);
    send_cmd(CMD_WRITE, 8'h11, 7'd0, 1'b0);
    send_cmd(CMD_WRITE, 8'h22, 7'd0, 1'b0);
    send_cmd(CMD_TICK, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_WRITE, 8'h33, 7'd0, 1'b0);
    send_cmd(CMD_READ, 8'h00, 7'd64, 1'b0);
    send_cmd(CMD_WRITE, 8'h44, 7'd0, 1'b0);
    send_cmd(CMD_WRITE, 8'h55, 7'd0, 1'b0);
    send_cmd(CMD_TICK, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_FLUSH, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_WRITE, 8'h66, 7'd0, 1'b0);
    send_cmd(CMD_READ, 8'h00, 7'd64, 1'b1);
    send_cmd(CMD_READ, 8'h00, 7'd64, 1'b0);
  endtask

  // Fill to the brim, drop on full, then read across the ring wrap
  task automatic test_full_fifo();
    write_config(CFG_PACKET_MODE, 16'd0);
    send_cmd(CMD_FLUSH, 8'h00, 7'd0, 1'b0);
    repeat (DEPTH) send_cmd(CMD_WRITE, 8'($urandom), 7'($urandom), 1'($urandom));
    send_cmd(CMD_WRITE, 8'hEE, 7'd0, 1'b0);
    send_cmd(CMD_TICK, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_WRITE, 8'hDD, 7'd0, 1'b0);
    send_cmd(CMD_READ, 8'h00, 7'd10, 1'b0);
    repeat (10) send_cmd(CMD_WRITE, 8'($urandom), 7'($urandom), 1'($urandom));
    send_cmd(CMD_READ, 8'h00, 7'h7F, 1'b0);
    send_cmd(CMD_READ, 8'h00, 7'd5, 1'b0);
  endtask

  // With the largest gap setting no packet ever becomes ready
  task automatic test_largest_gap();
    write_config(CFG_IDLE_GAP, 16'hFFFF);
    send_cmd(CMD_FLUSH, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_WRITE, 8'h7E, 7'd0, 1'b0);
    repeat (4) send_cmd(CMD_TICK, 8'h00, 7'd0, 1'b0);
    send_cmd(CMD_READ, 8'h00, 7'd64, 1'b1);
    send_cmd(CMD_READ, 8'h00, 7'd64, 1'b0);
  endtask

  // A run of bytes, roughly enough ticks to close the packet, then a read
  task automatic send_packet_burst();
    int unsigned n_bytes;
    int unsigned n_ticks;
    n_bytes = $urandom_range(1, 12);
    n_ticks = (gap_setting < 8) ? gap_setting + $urandom_range(0, 2)
                                : $urandom_range(0, 3);
    repeat (n_bytes) send_cmd(CMD_WRITE, 8'($urandom), 7'($urandom), 1'($urandom));
    repeat (n_ticks) send_cmd(CMD_TICK, 8'($urandom), 7'($urandom), 1'($urandom));
    send_cmd(CMD_READ, 8'($urandom), 7'($urandom_range(1, 64)),
             $urandom_range(0, 3) != 0);
  endtask

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.command     = (r < 35) ? CMD_WRITE : (r < 65) ? CMD_TICK :
                     (r < 92) ? CMD_READ : CMD_FLUSH;
    it.data_in     = 8'($urandom);
    it.read_limit  = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                 : 7'($urandom_range(0, 10));
    it.packet_only = 1'($urandom);
    return it;
  endfunction

  // Several register settings, each with packet bursts mixed with noise
  task automatic test_random_traffic();
    int unsigned phase_end;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_config(CFG_IDLE_GAP, 16'd0);
          write_config(CFG_PACKET_MODE, {15'($urandom), 1'b1});
        end
        1: begin
          write_config(CFG_IDLE_GAP, 16'($urandom_range(1, 4)));
          write_config(CFG_PACKET_MODE, {15'($urandom), 1'b0});
        end
        2: begin
          write_config(CFG_IDLE_GAP, 16'($urandom_range(1, 4)));
          write_config(CFG_PACKET_MODE, 16'd1);
        end
        3: begin
          write_config(CFG_IDLE_GAP, 16'hFFFF);
          write_config(CFG_PACKET_MODE, 16'd1);
        end
        default: begin
          write_config(CFG_IDLE_GAP, 16'($urandom_range(5, 12)));
          write_config(CFG_PACKET_MODE, 16'($urandom_range(0, 1)));
        end
      endcase
      phase_end = items_sent + 6;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 5) wait_until_drained();
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 45) send_packet_burst();
        else send_item(random_item());
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_IDLE_GAP;
    cfg_data    = '0;
    gap_setting = IDLE_GAP_RESET;
    pkt_mode    = 1'b0;
    idle_ticks  = 0;
    mismatches  = 0;
    items_sent  = 0;
    no_idle     = 1'b0;
    empty_ring();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_each_command();
    test_packet_mode();
    test_full_fifo();
    test_largest_gap();
    test_random_traffic();

    // Let the last results arrive, then watch for strays
    wait_until_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
